// ===== rtl/ldd_pkg.sv =====
package ldd_pkg;

  localparam int DefMaxCpus   = 64;
  localparam int DefPowerExp  = 1;
  localparam int DefStaleUs   = 10000000;

  localparam logic [16:0] OneQ16 = 17'd65536;

  localparam logic [2:0] RegMode        = 3'd0;
  localparam logic [2:0] RegTargetLoad  = 3'd1;
  localparam logic [2:0] RegAlphaShift  = 3'd2;
  localparam logic [2:0] RegLoadGain    = 3'd3;
  localparam logic [2:0] RegSimGain     = 3'd4;
  localparam logic [2:0] RegTargetDelay = 3'd5;
  localparam logic [2:0] RegTdfMin      = 3'd6;
  localparam logic [2:0] RegTdfMax      = 3'd7;

  localparam logic [1:0] ModeLoad = 2'd0;
  localparam logic [1:0] ModeSim  = 2'd1;
  localparam logic [1:0] ModeMax  = 2'd2;
  localparam logic [1:0] ModeOff  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRD,
    ST_SWAIT,
    ST_SCHK,
    ST_SDIV,
    ST_SFIN,
    ST_LEWMA,
    ST_LDIV,
    ST_LPOW,
    ST_LGAIN,
    ST_LUPD,
    ST_SCHECK,
    ST_SMUL,
    ST_SDIV2,
    ST_SUPD,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/ldd_if.sv =====
interface ldd_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [5:0]  cpu_index;
  logic [63:0] cpu_total;
  logic [63:0] cpu_idle;
  logic [63:0] sim_time_us;
  logic [31:0] sim_overhead_us;
  logic [63:0] now_us;
  modport source (output valid, action, cpu_index, cpu_total, cpu_idle, sim_time_us,
                  sim_overhead_us, now_us, input ready);
  modport sink (input valid, action, cpu_index, cpu_total, cpu_idle, sim_time_us,
                sim_overhead_us, now_us, output ready);
endinterface

interface ldd_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] required_tdf;
  modport source (output valid, required_tdf, input ready);
  modport sink (input valid, required_tdf, output ready);
endinterface

interface ldd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/load_and_delay_dilation_controller.sv =====
// Load and delay dilation controller. Counter samples (action 0) update a
// per-CPU idle ratio and a running minimum. Control steps (action 1) update
// the load controller (mode 0), the simulator controller (mode 1) or both
// (mode 2) and return one required_tdf word unless mode is 3. One shared
// 64-bit restoring divider step (one quotient bit a cycle) and one shared
// 32x32 multiplier do all the arithmetic under a small sequencer, so the
// block takes one item at a time. After a word is taken, the input stays
// not ready while the sequencer works on it:
//   - a sample: RAM read, 16-step fraction;
//   - a sample whose slot is out of range: not held;
//   - a control step in mode 0: 64-step division, one multiply per
//     power-law step, gain, update; it is shorter when the load term is zero;
//   - a control step in mode 1: 64-step division; it is shorter when the
//     report is stale;
//   - a control step in mode 2: both paths back to back;
//   - a control step in mode 3: not held.
// The result sits in an output register, and the next item is taken while it
// waits. A new result holds the sequencer in its output state until the
// previous one has left. Previous counters live in two RAMs with registered
// read. Per-slot valid bits guard them, so no clearing pass is needed.
module load_and_delay_dilation_controller
  import ldd_pkg::*;
#(
  parameter int MaxCpus  = DefMaxCpus,
  parameter int PowerExp = DefPowerExp,
  parameter int StaleUs  = DefStaleUs
) (
  input  logic clk,
  input  logic rst_n,
  ldd_in_if.sink   in_ch,
  ldd_out_if.source out_ch,
  ldd_cfg_if.sink  cfg_ch
);
  localparam int AW = (MaxCpus > 1) ? $clog2(MaxCpus) : 1;

  // configuration
  logic [1:0]  mode_r;
  logic [15:0] target_load_r;
  logic [3:0]  alpha_r;
  logic [23:0] load_gain_r, sim_gain_r, tdf_min_r, tdf_max_r;
  logic [31:0] target_delay_r;

  // controller state
  logic [MaxCpus-1:0] seen_r;
  logic [16:0] min_r, avg_ratio_r;
  logic [31:0] avg_delay_r;
  logic [23:0] load_tdf_r, tdf_sim_r;

  // item latch
  logic [5:0]  idx_r;
  logic [63:0] tot_r, idl_r, st_r, now_r;
  logic [31:0] ovh_r;

  state_t state_r, state_nxt;

  // divider / work registers
  logic [63:0] rem_r, quo_r, dvs_r;
  logic [6:0]  cnt_r;
  logic        neg_r;
  logic [63:0] p_r, m_r;
  logic [2:0]  pw_r;
  logic [23:0] out_data_r;
  logic        out_valid_r;

  logic [63:0]   rd_tot, rd_idl;
  logic          ram_we;
  logic [AW-1:0] slot_a;

  assign slot_a = AW'(idx_r);

  ldd_ram #(.Width(64), .Depth(MaxCpus)) u_tot (
    .clk(clk), .we(ram_we), .waddr(slot_a), .wdata(tot_r),
    .raddr(slot_a), .rdata(rd_tot));
  ldd_ram #(.Width(64), .Depth(MaxCpus)) u_idl (
    .clk(clk), .we(ram_we), .waddr(slot_a), .wdata(idl_r),
    .raddr(slot_a), .rdata(rd_idl));

  assign ram_we = (state_r == ST_SFIN);

  function automatic logic [23:0] bound_f(input logic signed [65:0] v,
                                          input logic [23:0] lo, input logic [23:0] hi);
    if (v < $signed({42'd0, lo})) return lo;
    if (v > $signed({42'd0, hi})) return hi;
    return v[23:0];
  endfunction

  // shared restoring divider step: 65-bit partial remainder
  logic [64:0] dv_sh;
  logic        dv_ge;
  logic [63:0] dv_rem;
  assign dv_sh  = {rem_r, quo_r[63]};
  assign dv_ge  = dv_sh >= {1'b0, dvs_r};
  assign dv_rem = dv_ge ? 64'(dv_sh - {1'b0, dvs_r}) : dv_sh[63:0];

  // shared multiplier, 32x32
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // ewma helper inputs
  logic signed [33:0] ew_avg, ew_x, ew_diff, ew_res;
  logic [33:0] ew_mag;
  always_comb begin
    if (state_r == ST_LEWMA) begin
      ew_avg = {17'd0, avg_ratio_r};
      ew_x   = {17'd0, min_r};
    end else begin
      ew_avg = {2'd0, avg_delay_r};
      ew_x   = {2'd0, ovh_r};
    end
    ew_diff = ew_x - ew_avg;
    ew_mag  = ew_diff[33] ? 34'(-ew_diff) : 34'(ew_diff);
    if (!ew_diff[33]) ew_res = ew_avg + $signed(ew_mag >> alpha_r);
    else ew_res = ew_avg - $signed((ew_mag + ((34'd1 << alpha_r) - 34'd1)) >> alpha_r);
  end

  logic [63:0] tot_eff, idl_eff, tgt_eff, st_diff, new_avg_delay;
  logic signed [17:0] num_s;
  logic [16:0] ratio;
  assign tgt_eff = (target_delay_r == 32'd0) ? 64'd1 : {32'd0, target_delay_r};
  assign st_diff = (st_r > now_r) ? st_r - now_r : now_r - st_r;
  assign num_s   = $signed({1'b0, avg_ratio_r}) - $signed({1'b0, 17'(OneQ16 - {1'b0, target_load_r})});
  assign new_avg_delay = {32'd0, ew_res[31:0]};
  assign tot_eff = tot_r;
  assign idl_eff = idl_r;
  // saturated cases carry their ratio in quo_r[0]
  assign ratio   = neg_r ? (quo_r[0] ? OneQ16 : 17'd0) : {1'b0, quo_r[15:0]};

  always_comb begin
    mul_a = p_r[31:0];
    mul_b = m_r[31:0];
    case (state_r)
      ST_LGAIN: begin mul_a = {8'd0, load_gain_r}; mul_b = p_r[31:0]; end
      ST_SMUL:  begin mul_a = {8'd0, sim_gain_r};  mul_b = m_r[31:0]; end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_ch.valid && in_ch.ready) begin
        if (!in_ch.action) begin
          state_nxt = ({58'd0, in_ch.cpu_index} >= 64'(MaxCpus)) ? ST_IDLE : ST_SRD;
        end else begin
          case (mode_r)
            ModeOff:  state_nxt = ST_IDLE;
            ModeSim:  state_nxt = ST_SCHECK;
            default:  state_nxt = ST_LEWMA;
          endcase
        end
      end
      ST_SRD:    state_nxt = ST_SWAIT;
      ST_SWAIT:  state_nxt = ST_SCHK;
      ST_SCHK:   state_nxt = ST_SDIV;
      ST_SDIV:   if (cnt_r == 7'd1) state_nxt = ST_SFIN;
      ST_SFIN:   state_nxt = ST_IDLE;
      ST_LEWMA:  state_nxt = ST_LDIV;
      ST_LDIV:   if (cnt_r <= 7'd1) state_nxt = ST_LPOW;
      ST_LPOW:   if (pw_r == 3'd0) state_nxt = ST_LGAIN;
      ST_LGAIN:  state_nxt = ST_LUPD;
      ST_LUPD:   state_nxt = (mode_r == ModeMax) ? ST_SCHECK : ST_OUT;
      ST_SCHECK: state_nxt = (st_diff >= 64'(StaleUs)) ? ST_OUT : ST_SMUL;
      ST_SMUL:   state_nxt = ST_SDIV2;
      ST_SDIV2:  if (cnt_r == 7'd1) state_nxt = ST_SUPD;
      ST_SUPD:   state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.required_tdf = out_data_r;

  logic [63:0] dt, di;
  assign dt = tot_eff - rd_tot;
  assign di = idl_eff - rd_idl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r <= ModeLoad; target_load_r <= 16'd52429; alpha_r <= 4'd3;
      load_gain_r <= 24'd65536; sim_gain_r <= 24'd65536;
      target_delay_r <= 32'd10000; tdf_min_r <= 24'd65536; tdf_max_r <= 24'd1048576;
      seen_r <= '0; min_r <= OneQ16; avg_ratio_r <= OneQ16;
      avg_delay_r <= 32'd10000; load_tdf_r <= 24'd65536; tdf_sim_r <= 24'd65536;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready && state_r != ST_OUT) out_valid_r <= 1'b0;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          RegMode:        mode_r <= cfg_ch.data[1:0];
          RegTargetLoad:  target_load_r <= cfg_ch.data[15:0];
          RegAlphaShift:  alpha_r <= cfg_ch.data[3:0];
          RegLoadGain:    load_gain_r <= cfg_ch.data[23:0];
          RegSimGain:     sim_gain_r <= cfg_ch.data[23:0];
          RegTargetDelay: target_delay_r <= cfg_ch.data;
          RegTdfMin:      tdf_min_r <= cfg_ch.data[23:0];
          RegTdfMax:      tdf_max_r <= cfg_ch.data[23:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: if (in_ch.valid) begin
          idx_r <= in_ch.cpu_index;
          tot_r <= (in_ch.cpu_total == 64'd0) ? 64'd1 : in_ch.cpu_total;
          idl_r <= (in_ch.cpu_idle == 64'd0) ? 64'd1 : in_ch.cpu_idle;
          st_r <= in_ch.sim_time_us; now_r <= in_ch.now_us; ovh_r <= in_ch.sim_overhead_us;
        end
        ST_SCHK: begin
          // pick numerator/denominator; the fraction runs for 16 steps
          cnt_r <= 7'd16;
          if (seen_r[slot_a] && tot_eff > rd_tot) begin
            dvs_r <= dt;
            neg_r <= (idl_eff < rd_idl) || (di >= dt);
            quo_r <= (idl_eff >= rd_idl && di >= dt) ? 64'd1 : '0; // flag for saturate
            rem_r <= di;
          end else begin
            dvs_r <= tot_eff;
            neg_r <= (idl_eff >= tot_eff);
            quo_r <= (idl_eff >= tot_eff) ? 64'd1 : '0;
            rem_r <= idl_eff;
          end
        end
        ST_SDIV: begin
          // frac16 step on the shared divider; quo_r[63] stays zero here
          if (!neg_r) begin
            rem_r <= dv_rem;
            quo_r <= {quo_r[62:0], dv_ge};
          end
          cnt_r <= cnt_r - 7'd1;
        end
        ST_SFIN: begin
          seen_r[slot_a] <= 1'b1;
          if (idx_r == 6'd0 || ratio < min_r) min_r <= ratio;
        end
        ST_LEWMA: begin
          avg_ratio_r <= ew_res[16:0];
          cnt_r <= 7'd65;
        end
        ST_LDIV: begin
          if (cnt_r == 7'd65) begin
            if (target_load_r == 16'd0 || num_s == 18'sd0) begin
              cnt_r <= 7'd0; pw_r <= 3'd0; m_r <= '0; p_r <= '0;
            end else begin
              dvs_r <= {48'd0, target_load_r};
              quo_r <= {30'd0, (num_s[17] ? 18'(-num_s) : num_s), 16'd0};
              rem_r <= '0; neg_r <= (num_s > 18'sd0);
              cnt_r <= 7'd64;
            end
          end else begin
            rem_r <= dv_rem; quo_r <= {quo_r[62:0], dv_ge};
            cnt_r <= cnt_r - 7'd1;
            if (cnt_r == 7'd1) begin
              m_r <= ({quo_r[62:0], dv_ge} > 64'hFFFFFFFF) ? 64'hFFFFFFFF
                     : {quo_r[62:0], dv_ge};
              p_r <= 64'd65536;
              pw_r <= 3'(PowerExp);
            end
          end
        end
        ST_LPOW: if (pw_r != 3'd0) begin
          p_r <= ((mul_p >> 16) > 64'hFFFFFFFF) ? 64'hFFFFFFFF : (mul_p >> 16);
          pw_r <= pw_r - 3'd1;
        end
        ST_LGAIN: p_r <= (mul_p >> 16) << PowerExp;
        ST_LUPD: if (target_load_r != 16'd0 && num_s != 18'sd0) begin
          if (neg_r) load_tdf_r <= bound_f($signed({42'd0, load_tdf_r}) - $signed({2'b0, p_r}),
                                           tdf_min_r, tdf_max_r);
          else load_tdf_r <= bound_f($signed({42'd0, load_tdf_r}) + $signed({2'b0, p_r}),
                                     tdf_min_r, tdf_max_r);
        end
        ST_SCHECK: begin
          if (st_diff >= 64'(StaleUs)) tdf_sim_r <= tdf_min_r;
          else begin
            avg_delay_r <= new_avg_delay[31:0];
            neg_r <= ({2'd0, new_avg_delay[31:0]} < {2'd0, tgt_eff[31:0]});
            m_r <= ({1'b0, new_avg_delay[31:0]} < {1'b0, tgt_eff[31:0]})
                   ? {32'd0, 32'(tgt_eff[31:0] - new_avg_delay[31:0])}
                   : {32'd0, 32'(new_avg_delay[31:0] - tgt_eff[31:0])};
          end
        end
        ST_SMUL: begin
          quo_r <= mul_p; rem_r <= '0; dvs_r <= tgt_eff; cnt_r <= 7'd64;
        end
        ST_SDIV2: begin
          rem_r <= dv_rem; quo_r <= {quo_r[62:0], dv_ge}; cnt_r <= cnt_r - 7'd1;
        end
        ST_SUPD: begin
          if (neg_r) tdf_sim_r <= bound_f($signed({42'd0, tdf_sim_r}) - $signed({2'b0, quo_r}),
                                          tdf_min_r, tdf_max_r);
          else tdf_sim_r <= bound_f($signed({42'd0, tdf_sim_r}) + $signed({2'b0, quo_r}),
                                    tdf_min_r, tdf_max_r);
        end
        ST_OUT: if (!out_valid_r || out_ch.ready) begin
          out_valid_r <= 1'b1;
          case (mode_r)
            ModeLoad: out_data_r <= load_tdf_r;
            ModeSim:  out_data_r <= tdf_sim_r;
            default:  out_data_r <= (tdf_sim_r > load_tdf_r) ? tdf_sim_r : load_tdf_r;
          endcase
        end
        default: ;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT) else $error("result outside output state");
  a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
    min_r <= OneQ16) else $error("ratio above one");
endmodule

// ===== rtl/ldd_ram.sv =====
module ldd_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sim/load_and_delay_dilation_controller_tb.sv =====
`timescale 1ns / 100ps

module load_and_delay_dilation_controller_tb
  import ldd_pkg::*;
();

  // One word on the input channel.
  typedef struct {
    bit        action;
    bit [5:0]  cpu_index;
    bit [63:0] cpu_total;
    bit [63:0] cpu_idle;
    bit [63:0] sim_time_us;
    bit [31:0] sim_overhead_us;
    bit [63:0] now_us;
  } ctl_word_t;

  // Register set for one phase of the run.
  typedef struct {
    bit [1:0]  mode;
    bit [15:0] target_load;
    bit [3:0]  alpha_shift;
    bit [23:0] load_gain;
    bit [23:0] sim_gain;
    bit [31:0] target_delay;
    bit [23:0] tdf_min;
    bit [23:0] tdf_max;
  } reg_set_t;

  // Dilation predictor and the queue of required_tdf words still owed.
  class tdf_scoreboard;
    bit [23:0] owed_tdf[$];
    int        mismatches;
    int        matched;
    bit [1:0]  mode = ModeLoad;
    bit [15:0] target_load = 16'd52429;
    bit [3:0]  alpha_shift = 4'd3;
    bit [23:0] load_gain = 24'd65536;
    bit [23:0] sim_gain = 24'd65536;
    bit [31:0] target_delay = 32'd10000;
    bit [23:0] tdf_min = 24'd65536;
    bit [23:0] tdf_max = 24'd1048576;
    bit [63:0] last_total[64];
    bit [63:0] last_idle[64];
    bit        slot_valid[64];
    bit [16:0] min_ratio = OneQ16;
    bit [16:0] avg_ratio = OneQ16;
    bit [31:0] avg_delay = 32'd10000;
    bit [23:0] load_tdf = 24'd65536;
    bit [23:0] tdf_sim = 24'd65536;

    function bit [16:0] idle_frac(bit [63:0] n, bit [63:0] d);
      bit [79:0] wide;
      if (n >= d) return OneQ16;
      wide = {n, 16'h0};
      return 17'(wide / d);
    endfunction

    // Floor moving average: arithmetic shift of the signed difference.
    function longint smooth(longint avg, longint x);
      longint d;
      d = x - avg;
      return avg + (d >>> alpha_shift);
    endfunction

    function bit [23:0] clamp(longint v);
      if (v < longint'(tdf_min)) return tdf_min;
      if (v > longint'(tdf_max)) return tdf_max;
      return 24'(v);
    endfunction

    function void note_cfg(bit [2:0] idx, bit [31:0] data);
      case (idx)
        RegMode:        mode = data[1:0];
        RegTargetLoad:  target_load = data[15:0];
        RegAlphaShift:  alpha_shift = data[3:0];
        RegLoadGain:    load_gain = data[23:0];
        RegSimGain:     sim_gain = data[23:0];
        RegTargetDelay: target_delay = data;
        RegTdfMin:      tdf_min = data[23:0];
        RegTdfMax:      tdf_max = data[23:0];
        default: ;
      endcase
    endfunction

    function void take_sample(ctl_word_t w);
      bit [63:0] tot, idl;
      bit [16:0] r;
      tot = (w.cpu_total == 0) ? 64'd1 : w.cpu_total;
      idl = (w.cpu_idle == 0) ? 64'd1 : w.cpu_idle;
      if (slot_valid[w.cpu_index] && tot > last_total[w.cpu_index]) begin
        if (idl < last_idle[w.cpu_index]) r = '0;
        else r = idle_frac(idl - last_idle[w.cpu_index], tot - last_total[w.cpu_index]);
      end else begin
        r = idle_frac(idl, tot);
      end
      last_total[w.cpu_index] = tot;
      last_idle[w.cpu_index] = idl;
      slot_valid[w.cpu_index] = 1'b1;
      if (w.cpu_index == 0 || r < min_ratio) min_ratio = r;
    endfunction

    function void load_update();
      longint    num;
      bit [63:0] mag, m, p, delta;
      avg_ratio = 17'(smooth(longint'(avg_ratio), longint'(min_ratio)));
      if (target_load == 0) return;
      num = longint'(avg_ratio) - (65536 - longint'(target_load));
      if (num == 0) return;
      mag = (num < 0) ? 64'(-num) : 64'(num);
      m = (mag << 16) / target_load;
      if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
      p = 64'd65536;
      for (int i = 0; i < DefPowerExp; i++) begin
        p = (p * m) >> 16;
        if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      end
      delta = ((64'(load_gain) * p) >> 16) << DefPowerExp;
      if (num > 0) load_tdf = clamp(longint'(load_tdf) - longint'(delta));
      else load_tdf = clamp(longint'(load_tdf) + longint'(delta));
    endfunction

    function void sim_update(ctl_word_t w);
      bit [63:0] gap;
      longint    tgt, err, prod;
      gap = (w.sim_time_us > w.now_us) ? w.sim_time_us - w.now_us
                                       : w.now_us - w.sim_time_us;
      tgt = (target_delay == 0) ? 1 : longint'(target_delay);
      if (gap >= 64'(DefStaleUs)) begin
        tdf_sim = tdf_min;
        return;
      end
      avg_delay = 32'(smooth(longint'(avg_delay), longint'(w.sim_overhead_us)));
      err = longint'(avg_delay) - tgt;
      prod = longint'(sim_gain) * err;
      tdf_sim = clamp(longint'(tdf_sim) + prod / tgt);
    endfunction

    function void note_word(ctl_word_t w);
      bit [23:0] want;
      if (!w.action) begin
        take_sample(w);
        return;
      end
      if (mode == ModeOff) return;
      if (mode == ModeLoad || mode == ModeMax) load_update();
      if (mode == ModeSim || mode == ModeMax) sim_update(w);
      if (mode == ModeLoad) want = load_tdf;
      else if (mode == ModeSim) want = tdf_sim;
      else want = (tdf_sim > load_tdf) ? tdf_sim : load_tdf;
      owed_tdf.insert(owed_tdf.size(), want);
    endfunction

    function void check_result(bit [23:0] got);
      bit [23:0] want;
      if (owed_tdf.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected required_tdf %0d", got);
        return;
      end
      want = owed_tdf.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("required_tdf mismatch: expected %0d actual %0d", want, got);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ldd_in_if  in_ch();
  ldd_out_if out_ch();
  ldd_cfg_if cfg_ch();

  load_and_delay_dilation_controller uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tdf_scoreboard tdf_sb = new();

  // Stimulus bookkeeping: per-slot cumulative counters and a wall clock.
  bit [63:0] slot_total[64];
  bit [63:0] slot_idle[64];
  bit [63:0] wall_us = 64'd50_000_000;
  bit        in_held;          // input valid currently high
  bit        calm;             // no idling on either side in this stretch
  int        stall_left;
  int        quiet_cycles;
  int        words_sent;
  int        steps_sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Pick a gap: mostly none or short, now and then long.
  function int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stall pattern on ready, check every accepted word.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) tdf_sb.check_result(out_ch.required_tdf);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  // Watchdog: end the run when no channel has moved a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == 5000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Send one word; lower valid only when a gap actually follows.
  task automatic send_word(ctl_word_t w);
    int g;
    g = pick_gap();
    if (g > 0 && in_held) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end
    repeat (g) @(posedge clk);
    in_ch.valid           <= 1'b1;
    in_ch.action          <= w.action;
    in_ch.cpu_index       <= w.cpu_index;
    in_ch.cpu_total       <= w.cpu_total;
    in_ch.cpu_idle        <= w.cpu_idle;
    in_ch.sim_time_us     <= w.sim_time_us;
    in_ch.sim_overhead_us <= w.sim_overhead_us;
    in_ch.now_us          <= w.now_us;
    in_held = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    tdf_sb.note_word(w);
    words_sent++;
    if (w.action) steps_sent++;
  endtask

  // Drain: drop valid, wait out every owed word, then let a trailing
  // sample finish inside the block.
  task automatic drain();
    if (in_held) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end
    while (tdf_sb.owed_tdf.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(bit [2:0] idx, bit [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    tdf_sb.note_cfg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(reg_set_t r);
    write_reg(RegMode, 32'(r.mode));
    write_reg(RegTargetLoad, 32'(r.target_load));
    write_reg(RegAlphaShift, 32'(r.alpha_shift));
    write_reg(RegLoadGain, 32'(r.load_gain));
    write_reg(RegSimGain, 32'(r.sim_gain));
    write_reg(RegTargetDelay, r.target_delay);
    write_reg(RegTdfMin, 32'(r.tdf_min));
    write_reg(RegTdfMax, 32'(r.tdf_max));
  endtask

  function ctl_word_t sample_word(bit [5:0] idx, bit [63:0] tot, bit [63:0] idl);
    ctl_word_t w;
    w = '{default: '0};
    w.cpu_index = idx;
    w.cpu_total = tot;
    w.cpu_idle  = idl;
    w.sim_time_us = {$urandom, $urandom};
    return w;
  endfunction

  function ctl_word_t step_word(bit [63:0] st, bit [63:0] now, bit [31:0] ovh);
    ctl_word_t w;
    w = '{default: '0};
    w.action = 1'b1;
    w.cpu_index = 6'($urandom);
    w.sim_time_us = st;
    w.now_us = now;
    w.sim_overhead_us = ovh;
    return w;
  endfunction

  // Well-formed traffic: counters that advance per slot, timestamps near
  // the wall clock; the rest is fully random noise.
  function ctl_word_t random_word(bit [31:0] tgt_delay);
    ctl_word_t w;
    bit [5:0]  idx;
    bit [63:0] dt, di;
    bit [63:0] st;
    int        roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      w.action          = 1'($urandom);
      w.cpu_index       = 6'($urandom);
      w.cpu_total       = {$urandom, $urandom};
      w.cpu_idle        = {$urandom, $urandom};
      w.sim_time_us     = {$urandom, $urandom};
      w.sim_overhead_us = $urandom;
      w.now_us          = {$urandom, $urandom};
      return w;
    end
    if (roll < 40) begin
      wall_us += $urandom_range(1000, 2_000_000);
      if ($urandom_range(0, 99) < 85) begin
        st = $urandom_range(0, 1) ? wall_us - $urandom_range(0, 9_999_999)
                                  : wall_us + $urandom_range(0, 9_999_999);
      end else begin
        st = wall_us - $urandom_range(10_000_000, 40_000_000);
      end
      if (tgt_delay > 32'd1_000_000) return step_word(st, wall_us, $urandom);
      return step_word(st, wall_us, $urandom_range(0, 3 * tgt_delay + 10));
    end
    idx = ($urandom_range(0, 99) < 60) ? 6'($urandom_range(0, 3)) : 6'($urandom);
    dt = $urandom_range(1, 5000);
    di = ($urandom_range(0, 99) < 5) ? dt + $urandom_range(1, 100) : $urandom_range(0, dt);
    if ($urandom_range(0, 99) < 3) dt = 0;   // stalled counter now and then
    slot_total[idx] += dt;
    slot_idle[idx] += di;
    return sample_word(idx, slot_total[idx], slot_idle[idx]);
  endfunction

  reg_set_t phases[8];

  initial begin
    int n_items;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= 1'b0;
    in_ch.cpu_index <= '0;
    in_ch.cpu_total <= '0;
    in_ch.cpu_idle <= '0;
    in_ch.sim_time_us <= '0;
    in_ch.sim_overhead_us <= '0;
    in_ch.now_us <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= RegMode;
    cfg_ch.data <= '0;
    calm = 1'b0;

    phases[0] = '{ModeLoad, 16'd52429, 4'd3, 24'd65536, 24'd65536, 32'd10000,
                  24'd65536, 24'd1048576};
    phases[1] = '{ModeSim, 16'd52429, 4'd0, 24'd65536, 24'hFFFFFF, 32'd10000,
                  24'd65536, 24'd1048576};
    phases[2] = '{ModeMax, 16'hFFFF, 4'd15, 24'hFFFFFF, 24'd65536, 32'd1,
                  24'd0, 24'hFFFFFF};
    phases[3] = '{ModeMax, 16'd0, 4'd1, 24'd300000, 24'd100, 32'hFFFF_FFFF,
                  24'd65536, 24'hFFFFFF};
    phases[4] = '{ModeLoad, 16'd1, 4'd2, 24'hFFFFFF, 24'd0, 32'd0,
                  24'd200000, 24'd100000};
    phases[5] = '{ModeOff, 16'd30000, 4'd5, 24'd65536, 24'd65536, 32'd10000,
                  24'd65536, 24'd1048576};
    phases[6] = '{ModeSim, 16'd40000, 4'd4, 24'd65536, 24'd200000, 32'd5000,
                  24'd0, 24'hFFFFFF};
    phases[7] = '{ModeMax, 16'd52429, 4'd3, 24'd65536, 24'd65536, 32'd10000,
                  24'd65536, 24'd1048576};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at reset settings: counter corner cases, then steps.
    send_word(sample_word(6'd0, 64'd0, 64'd0));                 // zeros read as one
    send_word(sample_word(6'd1, 64'd1000, 64'd100));            // first sample
    send_word(sample_word(6'd1, 64'd2000, 64'd150));            // normal delta
    send_word(sample_word(6'd1, 64'd1500, 64'd300));            // total ran backward
    send_word(sample_word(6'd1, 64'd3000, 64'd200));            // idle ran backward
    send_word(sample_word(6'd1, 64'd3000, 64'd900));            // zero total delta
    send_word(sample_word(6'd2, 64'd100, 64'd500));             // idle above total
    send_word(sample_word(6'd2, 64'd200, 64'd700));             // idle delta too big
    send_word(sample_word(6'd63, '1, '1));                      // all ones
    send_word(sample_word(6'd63, '1, 64'd5));                   // no forward delta
    send_word(step_word(64'd20_000_000, 64'd20_000_000, 32'd10000));
    send_word(sample_word(6'd0, 64'h8000_0000_0000_0000, 64'd1));
    send_word(step_word(64'd30_000_000, 64'd20_000_001, 32'd0));  // just fresh
    send_word(step_word(64'd30_000_000, 64'd20_000_000, 32'd0));  // just stale
    send_word(step_word(64'd0, '1, '1));                          // very stale
    send_word(step_word(64'd5, 64'd5, '1));                       // overhead max
    send_word(step_word('1, '1, 32'd1));
    drain();
    write_reg(RegMode, 32'(ModeMax));
    send_word(step_word(64'd100, 64'd200, 32'd20000));
    send_word(step_word(64'd100, 64'd200, 32'd0));
    send_word(sample_word(6'd0, 64'd10, 64'd1));
    send_word(step_word(64'd100, 64'd100, 32'd10000));
    drain();

    // Random phases, each with its own register set; every register is
    // written in every phase.
    for (int ph = 0; ph < 8; ph++) begin
      load_regs(phases[ph]);
      n_items = $urandom_range(90, 110);
      for (int k = 0; k < n_items; k++) begin
        if (k % 30 == 0) calm = ($urandom_range(0, 3) == 0);
        send_word(random_word(phases[ph].target_delay));
      end
      calm = 1'b0;
      drain();
    end

    $display("Covered %0d words (%0d control steps), %0d dilation results checked,",
             words_sent, steps_sent, tdf_sb.matched);
    $display("across all four modes and extreme gain, bound and target settings.");
    if (tdf_sb.mismatches == 0 && tdf_sb.owed_tdf.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", tdf_sb.mismatches,
               tdf_sb.owed_tdf.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ldd_pkg.sv
rtl/ldd_if.sv
rtl/ldd_ram.sv
rtl/load_and_delay_dilation_controller.sv
sim/load_and_delay_dilation_controller_tb.sv
